/* design/fvsm_pkg.sv */
// fvsm_pkg: shared types and constants of the four-voice synth mixer
// used by the arithmetic unit, the top level and the port checker
`default_nettype none

package fvsm_pkg;

   // operation of the shared arithmetic unit
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_MUL = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic       b_signed;   // multiplier operand b taken as signed
   } alu_ctl_type;

   // request kind carried in req_tuser
   localparam logic OP_RENDER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_MASTER_GAIN    = 2'd0;
   localparam logic [1:0] CSR_TICK_PERIOD    = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_ENABLED = 2'd2;

   localparam logic [1:0] NOISE_VOICE = 2'd3;
   localparam logic [7:0] SILENCE     = 8'd128;

   localparam logic [8:0]  GAIN_RESET   = 9'd256;
   localparam logic [14:0] PERIOD_RESET = 15'd1250;

endpackage

`default_nettype wire

/* design/fvsm_alu.sv */
// fvsm_alu: shared arithmetic unit of the mixer, a 16-bit adder and a
// 9x10 signed multiplier behind one result port; needs fvsm_pkg
`default_nettype none

module fvsm_alu (
   input  fvsm_pkg::alu_ctl_type ctl,
   input  logic [15:0]           opa,
   input  logic [15:0]           opb,
   output logic [18:0]           result
);
   import fvsm_pkg::*;

   logic signed [8:0]  mul_a;
   logic signed [9:0]  mul_b;
   logic signed [18:0] prod;
   logic [15:0]        sum;

   always_comb begin
      // operand a is an 8-bit signed value, operand b a 9-bit value
      mul_a  = signed'({opa[7], opa[7:0]});
      mul_b  = signed'({ctl.b_signed & opb[8], opb[8:0]});
      prod   = mul_a * mul_b;
      sum    = opa + opb;
      case (ctl.op)
         ALU_ADD: result = {3'b000, sum};
         ALU_MUL: result = prod;
         default: result = {3'b000, sum};
      endcase
   end

endmodule

`default_nettype wire

/* design/four_voice_chip_synth_mixer.sv */
// four_voice_chip_synth_mixer: oscillator state, sequencer and output stage
// of the four-voice mixer; needs fvsm_pkg and fvsm_alu
//
// Usage:
//   req channel: one beat is either a render request (req_tuser = 0) or a
//   voice load (req_tuser = 1). A load updates frequency/seed and volume in
//   the beat's own cycle and gives no result; req_tready stays high.
//   A render gives exactly one rsp beat: the 8-bit sample and the divider
//   tick flag. It runs through the shared adder/multiplier: three phase
//   updates, the triangle product, three mix adds and the gain product;
//   with output disabled a render skips them and gives silence (128) with
//   no tick. req_tready is low while a render is in progress.
//   rsp channel: one output register; a new request is taken while a
//   result waits, and a finished render waits in its last step until
//   the output register is free, so a stalled receiver holds everything.
//   csr channel: always ready; index 0 master gain, 1 tick period,
//   2 output enable, other indexes ignored. Write only while idle.
//   Reset: synchronous; gain 256, period 1250, output enabled, phases,
//   steps and volumes zero, noise register 1, no result pending.
`default_nettype none

module four_voice_chip_synth_mixer (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // voice[1:0], freq[17:2], vol[25:18], zero[31:26]
   input  logic        req_tuser,   // op
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // sample[7:0]
   output logic        rsp_tuser,   // seq_tick
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);
   import fvsm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_TRI,
      ST_MIX,
      ST_GAIN,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic [15:0] acc_ff [3];
   logic [15:0] acc_in [3];
   logic [15:0] step_ff [3];
   logic [15:0] step_in [3];
   logic [7:0]  vol_ff [4];
   logic [7:0]  vol_in [4];
   logic [15:0] noise_ff, noise_in;
   logic [14:0] tick_cnt_ff, tick_cnt_in;
   logic [7:0]  mix_ff, mix_in;

   logic [8:0]  gain_ff, gain_in;
   logic [14:0] period_ff, period_in;
   logic        enable_ff, enable_in;

   logic [7:0]  res_sample_ff, res_sample_in;
   logic        res_tick_ff, res_tick_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_sample_ff, rsp_sample_in;
   logic        rsp_tick_ff, rsp_tick_in;

   alu_ctl_type alu_ctl;
   logic [15:0] alu_a, alu_b;
   logic [18:0] alu_res;

   logic        req_beat;
   logic [1:0]  req_voice;
   logic [15:0] req_freq;
   logic [7:0]  req_vol;
   logic [7:0]  tri_b, tri_f, tri_t;
   logic [7:0]  part_mag;
   logic        part_neg;
   logic [7:0]  part;
   logic signed [10:0] gain_q;
   logic signed [11:0] gain_s;
   logic [15:0] tick_next;

   fvsm_alu u_alu (
      .ctl    (alu_ctl),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_res)
   );

   assign req_voice  = req_tdata[1:0];
   assign req_freq   = req_tdata[17:2];
   assign req_vol    = req_tdata[25:18];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tuser  = rsp_tick_ff;

   // operand selection for the shared unit
   always_comb begin
      tri_b = acc_ff[2][15:8];
      tri_f = tri_b[7] ? ~tri_b : tri_b;
      tri_t = {tri_f[6:0], 1'b0} + 8'h80;
      case (cnt_ff)
         2'd0: begin
            part_mag = vol_ff[0];
            part_neg = acc_ff[0][15] & acc_ff[0][14];
         end
         2'd1: begin
            part_mag = vol_ff[1];
            part_neg = acc_ff[1][15];
         end
         default: begin
            part_mag = vol_ff[3];
            part_neg = noise_ff[15];
         end
      endcase
      part = part_neg ? 8'(8'd0 - part_mag) : part_mag;

      alu_ctl = '{op: ALU_ADD, b_signed: 1'b0};
      alu_a   = 16'd0;
      alu_b   = 16'd0;
      case (state_ff)
         ST_ACC: begin
            alu_a = acc_ff[cnt_ff];
            alu_b = step_ff[cnt_ff];
         end
         ST_TRI: begin
            alu_ctl = '{op: ALU_MUL, b_signed: 1'b1};
            alu_a   = {8'd0, tri_t};
            alu_b   = {7'd0, vol_ff[2][7], vol_ff[2]};
         end
         ST_MIX: begin
            alu_a = {8'd0, mix_ff};
            alu_b = {8'd0, part};
         end
         ST_GAIN: begin
            alu_ctl = '{op: ALU_MUL, b_signed: 1'b0};
            alu_a   = {8'd0, mix_ff};
            alu_b   = {7'd0, gain_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      vol_in        = vol_ff;
      noise_in      = noise_ff;
      tick_cnt_in   = tick_cnt_ff;
      mix_in        = mix_ff;
      gain_in       = gain_ff;
      period_in     = period_ff;
      enable_in     = enable_ff;
      res_sample_in = res_sample_ff;
      res_tick_in   = res_tick_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;
      rsp_tick_in   = rsp_tick_ff;

      // floor(mix * gain / 256) + 128, saturated
      gain_q    = signed'(alu_res[18:8]);
      gain_s    = 12'(gain_q) + 12'sd128;
      tick_next = {1'b0, tick_cnt_ff} + 16'd1;

      if (csr_valid) begin
         case (csr_index)
            CSR_MASTER_GAIN:    gain_in   = csr_data[8:0];
            CSR_TICK_PERIOD:    period_in = csr_data;
            CSR_OUTPUT_ENABLED: enable_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_tuser == OP_LOAD) begin
                  if (req_voice == NOISE_VOICE) begin
                     noise_in = req_freq;
                  end else begin
                     step_in[req_voice] = req_freq;
                  end
                  vol_in[req_voice] = req_vol;
               end else if (enable_ff) begin
                  cnt_in   = 2'd0;
                  state_in = ST_ACC;
               end else begin
                  res_sample_in = SILENCE;
                  res_tick_in   = 1'b0;
                  state_in      = ST_OUT;
               end
            end
         end
         ST_ACC: begin
            acc_in[cnt_ff] = alu_res[15:0];
            if (cnt_ff == 2'd2) begin
               cnt_in   = 2'd0;
               state_in = ST_TRI;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         ST_TRI: begin
            // floor(2*t*vol/256) keeps product bits 14..7
            mix_in   = alu_res[14:7];
            noise_in = {noise_ff[14:0], noise_ff[14] ^ noise_ff[13]};
            state_in = ST_MIX;
         end
         ST_MIX: begin
            mix_in = alu_res[7:0];
            if (cnt_ff == 2'd2) begin
               cnt_in   = 2'd0;
               state_in = ST_GAIN;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         ST_GAIN: begin
            if (gain_s < 12'sd0) begin
               res_sample_in = 8'd0;
            end else if (gain_s > 12'sd255) begin
               res_sample_in = 8'd255;
            end else begin
               res_sample_in = gain_s[7:0];
            end
            if (tick_next >= {1'b0, period_ff}) begin
               tick_cnt_in = 15'd0;
               res_tick_in = 1'b1;
            end else begin
               tick_cnt_in = tick_next[14:0];
               res_tick_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_sample_ff;
               rsp_tick_in   = res_tick_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mix_ff        <= mix_in;
      res_sample_ff <= res_sample_in;
      res_tick_ff   <= res_tick_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_tick_ff   <= rsp_tick_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '{default: 16'd0};
         step_ff      <= '{default: 16'd0};
         vol_ff       <= '{default: 8'd0};
         noise_ff     <= 16'd1;
         tick_cnt_ff  <= 15'd0;
         gain_ff      <= GAIN_RESET;
         period_ff    <= PERIOD_RESET;
         enable_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         step_ff      <= step_in;
         vol_ff       <= vol_in;
         noise_ff     <= noise_in;
         tick_cnt_ff  <= tick_cnt_in;
         gain_ff      <= gain_in;
         period_ff    <= period_in;
         enable_ff    <= enable_in;
      end
   end

endmodule

`default_nettype wire

/* design/fvsm_checker.sv */
// fvsm_checker: port-level checks of the four-voice mixer, bound to the
// top level; needs fvsm_pkg and four_voice_chip_synth_mixer
`default_nettype none

module fvsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tuser
);
   import fvsm_pkg::*;

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a render beat keeps the request side busy
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_RENDER |=> !req_tready)
      else $error("request taken during a render");

   // a load beat never makes a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_LOAD && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result after a voice load");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready
      |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind four_voice_chip_synth_mixer fvsm_checker u_fvsm_checker (.*);

`default_nettype wire
